@@ src/pfl_pkg.sv @@
`default_nettype none
package pfl_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [63:0] WINDOW_NS = 64'd1000000000;
	localparam logic [63:0] DECAY_NS  = 64'd30000000000;

	localparam logic [31:0] VIOL_SYN_RAISE = 32'd20;
	localparam logic [31:0] VIOL_PKT_RAISE = 32'd15;
	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [7:0] PROTO_ICMP = 8'd1;

	localparam logic [2:0] CFG_MODE   = 3'd0;
	localparam logic [2:0] CFG_PORT   = 3'd1;
	localparam logic [2:0] CFG_SYN    = 3'd2;
	localparam logic [2:0] CFG_PACKET = 3'd3;
	localparam logic [2:0] CFG_TCP    = 3'd4;
	localparam logic [2:0] CFG_UDP    = 3'd5;
	localparam logic [2:0] CFG_ICMP   = 3'd6;
	localparam logic [2:0] CFG_BYTE   = 3'd7;

	localparam logic [1:0] LEVEL_MAX = 2'd3;

	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		CLS_TCP, CLS_UDP, CLS_ICMP, CLS_OTHER
	} pclass_t;

	typedef enum logic [2:0] {
		RSN_PASS, RSN_BLOCKLIST, RSN_TCP, RSN_UDP, RSN_LEVEL, RSN_SYN, RSN_RATE, RSN_BYTES
	} reason_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] target_port;
		logic [31:0] syn_limit;
		logic [31:0] packet_limit;
		logic [31:0] tcp_limit;
		logic [31:0] udp_limit;
		logic [31:0] icmp_limit;
		logic [47:0] byte_limit;
	} cfg_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] len;
		logic        syn;
		logic [63:0] now;
		pclass_t     pclass;
		logic        drop;
		reason_t     reason;
		logic        policed;
	} req_t;

	typedef struct packed {
		logic [31:0] pkts;
		logic [47:0] bytes;
		logic [63:0] wstart;
		logic [63:0] lchg;
		logic [1:0]  level;
		logic [31:0] viol;
	} rec_t;

	typedef struct packed {
		logic valid;
		logic pop;
	} qctl_t;

endpackage
`default_nettype wire

@@ src/pfl_front.sv @@
`default_nettype none
module pfl_front import pfl_pkg::*; (
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] src_addr,
	input  wire logic [7:0]  protocol,
	input  wire logic [15:0] dest_port,
	input  wire logic [15:0] packet_length,
	input  wire logic        is_syn,
	input  wire logic [63:0] now_ns,
	input  wire logic        on_blocklist,
	input  wire logic        on_allowlist,
	input  wire cfg_t        cfg,
	input  wire logic        full,
	output logic             push,
	output req_t             push_data
);

	pclass_t cls;

	always_comb begin
		unique case (protocol)
			PROTO_TCP:  cls = CLS_TCP;
			PROTO_UDP:  cls = CLS_UDP;
			PROTO_ICMP: cls = CLS_ICMP;
			default:    cls = CLS_OTHER;
		endcase
	end

	assign in_ready = !full;
	assign push     = in_valid && !full;

	// classify: protocol blocks, lists, enable and port filter
	always_comb begin
		push_data.addr    = src_addr;
		push_data.len     = packet_length;
		push_data.syn     = is_syn;
		push_data.now     = now_ns;
		push_data.pclass  = cls;
		push_data.drop    = 1'b0;
		push_data.reason  = RSN_PASS;
		push_data.policed = 1'b0;
		if (cls == CLS_UDP && cfg.mode[2] && !on_allowlist) begin
			push_data.drop   = 1'b1;
			push_data.reason = RSN_UDP;
		end else if (cls == CLS_TCP && cfg.mode[1] && !on_allowlist) begin
			push_data.drop   = 1'b1;
			push_data.reason = RSN_TCP;
		end else if (on_blocklist) begin
			push_data.drop   = 1'b1;
			push_data.reason = RSN_BLOCKLIST;
		end else if (on_allowlist || !cfg.mode[0]) begin
			push_data.policed = 1'b0;
		end else if (cfg.target_port != 16'd0 && dest_port != cfg.target_port) begin
			push_data.policed = 1'b0;
		end else begin
			push_data.policed = 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ src/pfl_queue.sv @@
`default_nettype none
module pfl_queue import pfl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire req_t push_data,
	output logic      full,
	input  wire qctl_t ctl_in,
	output logic      valid,
	output req_t      head
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	req_t          slots_q [QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign full   = (cnt_q == CW'(QDEPTH));
	assign valid  = (cnt_q != '0);
	assign head   = slots_q[rd_q];
	assign do_pop = ctl_in.pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(do_pop);
		end
	end

endmodule
`default_nettype wire

@@ src/pfl_back.sv @@
`default_nettype none
module pfl_back import pfl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        q_valid,
	input  wire req_t        q_head,
	output qctl_t            q_ctl,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             verdict,
	output logic [2:0]       reason,
	output logic [1:0]       proto_class,
	output logic [1:0]       source_level,
	output logic [15:0]      counted_length
);

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_READ, ST_CALC, ST_DECIDE} state_t;

	state_t           state_q;
	req_t             req_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] idx_q;
	logic [IDX_W-1:0] slot_q;
	logic             found_q;

	logic [31:0] addr_mem [TABLE_ENTRIES];
	rec_t        rec_mem  [TABLE_ENTRIES];
	logic [31:0] rd_addr_s1;
	logic        pend_s1;
	logic [IDX_W-1:0] pidx_s1;
	rec_t        rec_s1;

	// calc stage results
	logic        expired_q;
	logic        decay_q;
	logic [31:0] pk_q;
	logic [47:0] bytes_q;
	logic [31:0] viol_inc_q;
	logic [31:0] lim_q;
	logic [34:0] lim2_q, lim4_q, lim6_q;

	logic        out_valid_q;
	logic        verdict_q;
	reason_t     reason_q;
	pclass_t     pclass_q;
	logic [1:0]  level_q;
	logic [15:0] len_q;

	logic        out_free;
	logic        hit;
	logic        wr_en;
	logic [IDX_W-1:0] wr_idx;
	rec_t        wr_rec;
	logic        alloc;
	logic        d_drop;
	reason_t     d_reason;
	logic [1:0]  d_level;
	logic [1:0]  raise_lvl;

	// calc-stage combinational terms
	logic [31:0] c_lim;
	logic [48:0] c_bsum;

	assign out_free = !out_valid_q || out_ready;
	assign hit      = pend_s1 && (rd_addr_s1 == req_q.addr);
	assign q_ctl.valid = q_valid;
	assign q_ctl.pop   = (state_q == ST_IDLE) && q_valid;

	// registered reads of both memories
	always_ff @(posedge clk) begin
		rd_addr_s1 <= addr_mem[idx_q[IDX_W-1:0]];
		pidx_s1    <= idx_q[IDX_W-1:0];
		rec_s1     <= rec_mem[slot_q];
		if (wr_en) begin
			rec_mem[wr_idx] <= wr_rec;
		end
		if (alloc) begin
			addr_mem[wr_idx] <= req_q.addr;
		end
	end

	always_comb begin
		unique case (req_q.pclass)
			CLS_TCP:  c_lim = cfg.tcp_limit;
			CLS_UDP:  c_lim = cfg.udp_limit;
			CLS_ICMP: c_lim = cfg.icmp_limit;
			default:  c_lim = 32'd0;
		endcase
		c_bsum = {1'b0, rec_s1.bytes} + {33'd0, req_q.len};
	end

	// decide: verdict and the entry's new contents
	always_comb begin
		wr_en     = 1'b0;
		alloc     = 1'b0;
		wr_idx    = slot_q;
		wr_rec    = rec_s1;
		d_drop    = req_q.drop;
		d_reason  = req_q.reason;
		d_level   = found_q ? rec_s1.level : 2'd0;
		raise_lvl = 2'd0;
		if (req_q.policed) begin
			if (!found_q) begin
				d_level = 2'd0;
				if (fill_q != CNT_W'(TABLE_ENTRIES)) begin
					alloc         = 1'b1;
					wr_en         = 1'b1;
					wr_idx        = fill_q[IDX_W-1:0];
					wr_rec.pkts   = 32'd1;
					wr_rec.bytes  = {32'd0, req_q.len};
					wr_rec.wstart = req_q.now;
					wr_rec.lchg   = req_q.now;
					wr_rec.level  = 2'd0;
					wr_rec.viol   = 32'd0;
				end
			end else if (rec_s1.level == LEVEL_MAX) begin
				d_drop   = 1'b1;
				d_reason = RSN_LEVEL;
			end else if (expired_q) begin
				wr_en = 1'b1;
				if (decay_q) begin
					wr_rec.level = rec_s1.level - 2'd1;
					wr_rec.lchg  = req_q.now;
				end
				wr_rec.pkts   = 32'd1;
				wr_rec.bytes  = {32'd0, req_q.len};
				wr_rec.wstart = req_q.now;
			end else begin
				wr_en        = 1'b1;
				wr_rec.pkts  = pk_q;
				wr_rec.bytes = bytes_q;
				if (req_q.syn && cfg.syn_limit != 32'd0 && pk_q > cfg.syn_limit) begin
					wr_rec.viol = viol_inc_q;
					if (viol_inc_q > VIOL_SYN_RAISE) begin
						wr_rec.level = rec_s1.level + 2'd1;
						wr_rec.lchg  = req_q.now;
					end
					d_drop   = 1'b1;
					d_reason = RSN_SYN;
				end else if (cfg.packet_limit != 32'd0 && pk_q > cfg.packet_limit) begin
					wr_rec.viol = viol_inc_q;
					if (viol_inc_q > VIOL_PKT_RAISE) begin
						wr_rec.level = rec_s1.level + 2'd1;
						wr_rec.lchg  = req_q.now;
					end
					d_drop   = 1'b1;
					d_reason = RSN_RATE;
				end else if (lim_q != 32'd0 && pk_q > lim_q) begin
					wr_rec.viol = viol_inc_q;
					if ({3'd0, pk_q} > lim6_q) begin
						raise_lvl = 2'd3;
					end else if ({3'd0, pk_q} > lim4_q) begin
						raise_lvl = 2'd2;
					end else if ({3'd0, pk_q} > lim2_q) begin
						raise_lvl = 2'd1;
					end
					if (rec_s1.level < raise_lvl) begin
						wr_rec.level = raise_lvl;
						wr_rec.lchg  = req_q.now;
					end
					d_drop   = 1'b1;
					d_reason = RSN_RATE;
				end else if (cfg.byte_limit != 48'd0 && bytes_q > cfg.byte_limit) begin
					wr_rec.viol = viol_inc_q;
					if (rec_s1.level < 2'd2) begin
						wr_rec.level = 2'd2;
						wr_rec.lchg  = req_q.now;
					end
					d_drop   = 1'b1;
					d_reason = RSN_BYTES;
				end
			end
			if (found_q) begin
				d_level = wr_rec.level;
			end
		end
		if (state_q != ST_DECIDE || !out_free) begin
			wr_en = 1'b0;
			alloc = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			slot_q      <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			expired_q   <= 1'b0;
			decay_q     <= 1'b0;
			pk_q        <= '0;
			bytes_q     <= '0;
			viol_inc_q  <= '0;
			lim_q       <= '0;
			lim2_q      <= '0;
			lim4_q      <= '0;
			lim6_q      <= '0;
			out_valid_q <= 1'b0;
			verdict_q   <= 1'b0;
			reason_q    <= RSN_PASS;
			pclass_q    <= CLS_TCP;
			level_q     <= '0;
			len_q       <= '0;
		end else begin
			pend_s1 <= (state_q == ST_SCAN) && (idx_q < fill_q) && !hit;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						req_q   <= q_head;
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						slot_q  <= pidx_s1;
						found_q <= 1'b1;
						state_q <= ST_READ;
					end else if (idx_q >= fill_q) begin
						state_q <= ST_CALC;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_READ: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					expired_q  <= (req_q.now - rec_s1.wstart) > WINDOW_NS;
					decay_q    <= (rec_s1.level != 2'd0) &&
						((req_q.now - rec_s1.lchg) > DECAY_NS);
					pk_q       <= (rec_s1.pkts == MAX32) ? MAX32 : rec_s1.pkts + 32'd1;
					bytes_q    <= c_bsum[48] ? MAX48 : c_bsum[47:0];
					viol_inc_q <= (rec_s1.viol == MAX32) ? MAX32 : rec_s1.viol + 32'd1;
					lim_q      <= c_lim;
					lim2_q     <= {2'd0, c_lim, 1'b0};
					lim4_q     <= {1'b0, c_lim, 2'b00};
					lim6_q     <= {1'b0, c_lim, 2'b00} + {2'd0, c_lim, 1'b0};
					state_q    <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (out_free) begin
						if (alloc) begin
							fill_q <= fill_q + 1'b1;
						end
						out_valid_q <= 1'b1;
						verdict_q   <= d_drop;
						reason_q    <= d_reason;
						pclass_q    <= req_q.pclass;
						level_q     <= d_level;
						len_q       <= req_q.len;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign verdict        = verdict_q;
	assign reason         = reason_q;
	assign proto_class    = pclass_q;
	assign source_level   = level_q;
	assign counted_length = len_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_ENTRIES))
		else $error("fill count beyond table size");

	a_slot_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && found_q) |-> ({1'b0, slot_q} < fill_q))
		else $error("matched slot not yet filled");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= fill_q))
		else $error("scan index past fill count");

	a_alloc_miss: assert property (@(posedge clk) disable iff (!arst_n)
		alloc |-> (!found_q && req_q.policed))
		else $error("allocation for a known source");

endmodule
`default_nettype wire

@@ src/per_source_flood_limiter.sv @@
`default_nettype none
// Channel   Handshake              Payload
// in        in_valid / in_ready    src_addr protocol dest_port packet_length is_syn
//                                  now_ns on_blocklist on_allowlist
// out       out_valid / out_ready  verdict reason proto_class source_level counted_length
// cfg       cfg_we (no stall)      cfg_index cfg_data
//
// A word goes through the table engine in turn: the lookup compares one stored address
// per cycle across the fill sources held, fill being their number, then a record read
// (known source only), a calc and a decide stage. The classifier and a two-word queue
// take new words while the engine works; decide holds while the output register has an
// unaccepted result. Reset clears the fill count, so the table is empty at once, no sweep.
module per_source_flood_limiter import pfl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] src_addr,
	input  wire logic [7:0]  protocol,
	input  wire logic [15:0] dest_port,
	input  wire logic [15:0] packet_length,
	input  wire logic        is_syn,
	input  wire logic [63:0] now_ns,
	input  wire logic        on_blocklist,
	input  wire logic        on_allowlist,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             verdict,
	output logic [2:0]       reason,
	output logic [1:0]       proto_class,
	output logic [1:0]       source_level,
	output logic [15:0]      counted_length
);

	cfg_t  cfg_q;
	logic  push;
	req_t  push_data;
	logic  full;
	logic  q_valid;
	req_t  q_head;
	qctl_t q_ctl;

	// register file: write only, keep the low bits each register needs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:   cfg_q.mode         <= cfg_data[2:0];
				CFG_PORT:   cfg_q.target_port  <= cfg_data[15:0];
				CFG_SYN:    cfg_q.syn_limit    <= cfg_data[31:0];
				CFG_PACKET: cfg_q.packet_limit <= cfg_data[31:0];
				CFG_TCP:    cfg_q.tcp_limit    <= cfg_data[31:0];
				CFG_UDP:    cfg_q.udp_limit    <= cfg_data[31:0];
				CFG_ICMP:   cfg_q.icmp_limit   <= cfg_data[31:0];
				CFG_BYTE:   cfg_q.byte_limit   <= cfg_data;
				default:    cfg_q              <= cfg_q;
			endcase
		end
	end

	// front: classify the word and drop it into the queue
	pfl_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.src_addr      (src_addr),
		.protocol      (protocol),
		.dest_port     (dest_port),
		.packet_length (packet_length),
		.is_syn        (is_syn),
		.now_ns        (now_ns),
		.on_blocklist  (on_blocklist),
		.on_allowlist  (on_allowlist),
		.cfg           (cfg_q),
		.full          (full),
		.push          (push),
		.push_data     (push_data)
	);

	pfl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.ctl_in    (q_ctl),
		.valid     (q_valid),
		.head      (q_head)
	);

	// back: source lookup, window accounting, verdict
	pfl_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_valid        (q_valid),
		.q_head         (q_head),
		.q_ctl          (q_ctl),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.verdict        (verdict),
		.reason         (reason),
		.proto_class    (proto_class),
		.source_level   (source_level),
		.counted_length (counted_length)
	);

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
module tb;
	import pfl_pkg::*;

	typedef struct {
		logic [31:0] addr;
		logic [7:0]  proto;
		logic [15:0] dport;
		logic [15:0] len;
		logic        syn;
		logic [63:0] now;
		logic        blk;
		logic        alw;
	} pkt_t;

	typedef struct {
		logic        drop;
		reason_t     why;
		pclass_t     cls;
		logic [1:0]  level;
		logic [15:0] len;
	} verdict_t;

	// One row of the directed table; typed rows carry their verdict, the rest use the predictor.
	typedef struct {
		pkt_t     p;
		bit       typed;
		verdict_t v;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] src_addr;
	logic [7:0]  protocol;
	logic [15:0] dest_port;
	logic [15:0] packet_length;
	logic        is_syn;
	logic [63:0] now_ns;
	logic        on_blocklist;
	logic        on_allowlist;
	logic        out_valid;
	logic        out_ready;
	logic        verdict;
	logic [2:0]  reason;
	logic [1:0]  proto_class;
	logic [1:0]  source_level;
	logic [15:0] counted_length;

	per_source_flood_limiter dut (.*);

	// Shadow of the limiter: its registers and its per-source table.
	cfg_t        regs;
	bit          sv_valid [TABLE_ENTRIES];
	logic [31:0] sv_addr  [TABLE_ENTRIES];
	logic [31:0] sv_pkts  [TABLE_ENTRIES];
	logic [47:0] sv_bytes [TABLE_ENTRIES];
	logic [63:0] sv_wstart[TABLE_ENTRIES];
	logic [63:0] sv_lchg  [TABLE_ENTRIES];
	logic [1:0]  sv_level [TABLE_ENTRIES];
	logic [31:0] sv_viol  [TABLE_ENTRIES];

	verdict_t    pending_verdicts[$];
	int          fails;
	int          words_sent;
	bit          quiet;
	logic [63:0] clock_ns;
	logic [31:0] src_pool[12];

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#40_000_000;
		$display("per_source_flood_limiter: mismatch");
		$finish;
	end

	function automatic pclass_t classify(logic [7:0] proto);
		if (proto == PROTO_TCP) return CLS_TCP;
		if (proto == PROTO_UDP) return CLS_UDP;
		if (proto == PROTO_ICMP) return CLS_ICMP;
		return CLS_OTHER;
	endfunction

	task automatic note_violation(int s);
		if (sv_viol[s] != MAX32) sv_viol[s]++;
	endtask

	// Raise the level to at least lvl, stamping the change time only if it moved.
	task automatic raise_level(int s, logic [1:0] lvl, logic [63:0] now);
		if (sv_level[s] < lvl) begin
			sv_level[s] = lvl;
			sv_lchg[s] = now;
		end
	endtask

	// Step the shadow table with one packet and work out the verdict it earns.
	task automatic judge_packet(input pkt_t p, output verdict_t r);
		int s;
		int i;
		logic [63:0] lim;
		logic [31:0] pk;
		logic [48:0] bsum;
		r.drop = 1'b0;
		r.why = RSN_PASS;
		r.cls = classify(p.proto);
		r.len = p.len;
		s = -1;
		for (i = 0; i < TABLE_ENTRIES; i++) begin
			if (s < 0 && sv_valid[i] && sv_addr[i] == p.addr) s = i;
		end
		if (p.proto == PROTO_UDP && regs.mode[2] && !p.alw) begin
			r.drop = 1'b1;
			r.why = RSN_UDP;
		end else if (p.proto == PROTO_TCP && regs.mode[1] && !p.alw) begin
			r.drop = 1'b1;
			r.why = RSN_TCP;
		end else if (p.blk) begin
			r.drop = 1'b1;
			r.why = RSN_BLOCKLIST;
		end else if (p.alw || !regs.mode[0]) begin
		end else if (regs.target_port != 0 && p.dport != regs.target_port) begin
		end else if (s < 0) begin
			// New source: claim the lowest free slot, or pass untracked when full.
			for (i = 0; i < TABLE_ENTRIES; i++) begin
				if (s < 0 && !sv_valid[i]) s = i;
			end
			if (s >= 0) begin
				sv_valid[s] = 1'b1;
				sv_addr[s] = p.addr;
				sv_pkts[s] = 32'd1;
				sv_bytes[s] = {32'd0, p.len};
				sv_wstart[s] = p.now;
				sv_lchg[s] = p.now;
				sv_level[s] = 2'd0;
				sv_viol[s] = 32'd0;
			end
		end else if (sv_level[s] == LEVEL_MAX) begin
			r.drop = 1'b1;
			r.why = RSN_LEVEL;
		end else if (p.now - sv_wstart[s] > WINDOW_NS) begin
			// Window restart; decay one level if quiet long enough.
			if (sv_level[s] > 0 && p.now - sv_lchg[s] > DECAY_NS) begin
				sv_level[s]--;
				sv_lchg[s] = p.now;
			end
			sv_pkts[s] = 32'd1;
			sv_bytes[s] = {32'd0, p.len};
			sv_wstart[s] = p.now;
		end else begin
			if (sv_pkts[s] != MAX32) sv_pkts[s]++;
			bsum = {1'b0, sv_bytes[s]} + p.len;
			sv_bytes[s] = bsum[48] ? MAX48 : bsum[47:0];
			pk = sv_pkts[s];
			case (r.cls)
				CLS_TCP:  lim = {32'd0, regs.tcp_limit};
				CLS_UDP:  lim = {32'd0, regs.udp_limit};
				CLS_ICMP: lim = {32'd0, regs.icmp_limit};
				default:  lim = 64'd0;
			endcase
			if (p.syn && regs.syn_limit != 0 && pk > regs.syn_limit) begin
				note_violation(s);
				if (sv_viol[s] > VIOL_SYN_RAISE && sv_level[s] < LEVEL_MAX) begin
					sv_level[s]++;
					sv_lchg[s] = p.now;
				end
				r.drop = 1'b1;
				r.why = RSN_SYN;
			end else if (regs.packet_limit != 0 && pk > regs.packet_limit) begin
				note_violation(s);
				if (sv_viol[s] > VIOL_PKT_RAISE && sv_level[s] < LEVEL_MAX) begin
					sv_level[s]++;
					sv_lchg[s] = p.now;
				end
				r.drop = 1'b1;
				r.why = RSN_RATE;
			end else if (lim != 0 && pk > lim) begin
				// Per-protocol overrun escalates at 2, 4 and 6 times the limit.
				note_violation(s);
				if (pk > lim * 6) raise_level(s, 2'd3, p.now);
				else if (pk > lim * 4) raise_level(s, 2'd2, p.now);
				else if (pk > lim * 2) raise_level(s, 2'd1, p.now);
				r.drop = 1'b1;
				r.why = RSN_RATE;
			end else if (regs.byte_limit != 0 && sv_bytes[s] > regs.byte_limit) begin
				note_violation(s);
				raise_level(s, 2'd2, p.now);
				r.drop = 1'b1;
				r.why = RSN_BYTES;
			end
		end
		r.level = (s >= 0) ? sv_level[s] : 2'd0;
	endtask

	// Write all eight registers back to back; junk in the upper bits must be ignored.
	task automatic load_regs(cfg_t c);
		logic [47:0] vals[8];
		logic [2:0]  idx[8];
		int i;
		vals[0] = {$urandom, 16'd0} | c.mode;
		vals[1] = {$urandom, 16'd0} | c.target_port;
		vals[2] = {16'($urandom_range(65535)), c.syn_limit};
		vals[3] = {16'($urandom_range(65535)), c.packet_limit};
		vals[4] = {16'($urandom_range(65535)), c.tcp_limit};
		vals[5] = {16'($urandom_range(65535)), c.udp_limit};
		vals[6] = {16'($urandom_range(65535)), c.icmp_limit};
		vals[7] = c.byte_limit;
		idx = '{CFG_MODE, CFG_PORT, CFG_SYN, CFG_PACKET, CFG_TCP, CFG_UDP, CFG_ICMP,
			CFG_BYTE};
		for (i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		regs = c;
	endtask

	// Offer one word, sometimes after a random gap, and hold it until taken.
	task automatic send_word(pkt_t p, bit typed, verdict_t fixed);
		verdict_t r;
		if (!quiet && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		src_addr <= p.addr;
		protocol <= p.proto;
		dest_port <= p.dport;
		packet_length <= p.len;
		is_syn <= p.syn;
		now_ns <= p.now;
		on_blocklist <= p.blk;
		on_allowlist <= p.alw;
		do @(posedge clk); while (!in_ready);
		judge_packet(p, r);
		pending_verdicts.push_back(typed ? fixed : r);
		words_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	// Mostly a small pool of sources with short steps in time, so windows fill and limits trip.
	function automatic pkt_t random_packet();
		pkt_t p;
		int pick;
		p.addr = ($urandom_range(99) < 92) ? src_pool[$urandom_range(11)] : $urandom;
		pick = $urandom_range(99);
		p.proto = pick < 40 ? PROTO_TCP : pick < 65 ? PROTO_UDP : pick < 85 ? PROTO_ICMP :
			8'($urandom);
		p.dport = ($urandom_range(99) < 60) ? regs.target_port : 16'($urandom);
		p.len = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40, 1500));
		p.syn = 1'($urandom_range(1));
		p.blk = $urandom_range(99) < 5;
		p.alw = $urandom_range(99) < 8;
		pick = $urandom_range(99);
		if (pick < 85) clock_ns += $urandom_range(1, 30_000_000);
		else if (pick < 93) clock_ns += 64'd1_200_000_000 + $urandom_range(0, 900_000_000);
		else if (pick < 97) clock_ns += 64'd31_000_000_000;
		else clock_ns -= $urandom_range(1, 2_000_000_000);
		p.now = clock_ns;
		return p;
	endfunction

	// Check each returned word against the oldest pending verdict.
	initial begin
		verdict_t e;
		forever begin
			out_ready <= quiet || $urandom_range(99) >= 9;
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_verdicts.size() == 0) begin
					$error("unexpected result word");
					fails++;
				end else begin
					e = pending_verdicts.pop_front();
					if (verdict !== e.drop) begin
						$error("verdict: expected %0d, got %0d", e.drop, verdict);
						fails++;
					end
					if (reason !== e.why) begin
						$error("reason: expected %0d, got %0d", e.why, reason);
						fails++;
					end
					if (proto_class !== e.cls) begin
						$error("proto_class: expected %0d, got %0d", e.cls, proto_class);
						fails++;
					end
					if (source_level !== e.level) begin
						$error("source_level: expected %0d, got %0d", e.level, source_level);
						fails++;
					end
					if (counted_length !== e.len) begin
						$error("counted_length: expected %0d, got %0d", e.len, counted_length);
						fails++;
					end
				end
			end
		end
	end

	initial begin
		row_t     rows[$];
		cfg_t     phases[5];
		verdict_t none;
		int i;
		int k;
		fails = 0;
		words_sent = 0;
		quiet = 1'b0;
		clock_ns = 64'd5_000_000_000;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		in_valid = 1'b0;
		src_addr = '0;
		protocol = '0;
		dest_port = '0;
		packet_length = '0;
		is_syn = 1'b0;
		now_ns = '0;
		on_blocklist = 1'b0;
		on_allowlist = 1'b0;
		regs = '0;
		for (i = 0; i < TABLE_ENTRIES; i++) sv_valid[i] = 1'b0;
		for (i = 0; i < 12; i++) src_pool[i] = $urandom;
		none = '{1'b0, RSN_PASS, CLS_OTHER, 2'd0, 16'd0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: filter off, so everything passes unless blocklisted.
		rows = '{
			'{'{32'h0, 8'd0, 16'h0, 16'h0, 1'b0, 64'h0, 1'b0, 1'b0}, 1'b1,
				'{1'b0, RSN_PASS, CLS_OTHER, 2'd0, 16'h0}},
			'{'{32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
				1'b0, 1'b0}, 1'b1, '{1'b0, RSN_PASS, CLS_OTHER, 2'd0, 16'hFFFF}},
			'{'{32'h0A00_0001, PROTO_TCP, 16'd80, 16'd60, 1'b1, 64'd10, 1'b0, 1'b0}, 1'b1,
				'{1'b0, RSN_PASS, CLS_TCP, 2'd0, 16'd60}},
			'{'{32'h0A00_0001, PROTO_UDP, 16'd53, 16'd100, 1'b0, 64'd20, 1'b0, 1'b0}, 1'b1,
				'{1'b0, RSN_PASS, CLS_UDP, 2'd0, 16'd100}},
			'{'{32'h0A00_0001, PROTO_ICMP, 16'd0, 16'd84, 1'b0, 64'd30, 1'b0, 1'b0}, 1'b1,
				'{1'b0, RSN_PASS, CLS_ICMP, 2'd0, 16'd84}},
			'{'{32'h0A00_0002, PROTO_TCP, 16'd22, 16'd40, 1'b0, 64'd40, 1'b1, 1'b0}, 1'b1,
				'{1'b1, RSN_BLOCKLIST, CLS_TCP, 2'd0, 16'd40}},
			'{'{32'h0A00_0002, PROTO_ICMP, 16'd0, 16'd40, 1'b0, 64'd50, 1'b1, 1'b1}, 1'b1,
				'{1'b1, RSN_BLOCKLIST, CLS_ICMP, 2'd0, 16'd40}}
		};
		foreach (rows[i]) send_word(rows[i].p, rows[i].typed, rows[i].v);
		drain();

		// Protocol blocking, port filter, new source, limits, time going backwards.
		load_regs('{3'd7, 16'd443, 32'd2, 32'd0, 32'd1, 32'd1, 32'd1, 48'd0});
		rows = '{
			'{'{32'h0B00_0001, PROTO_TCP, 16'd443, 16'd60, 1'b1, 64'd1000, 1'b0, 1'b0}, 1'b1,
				'{1'b1, RSN_TCP, CLS_TCP, 2'd0, 16'd60}},
			'{'{32'h0B00_0001, PROTO_UDP, 16'd443, 16'd60, 1'b0, 64'd1100, 1'b0, 1'b0}, 1'b1,
				'{1'b1, RSN_UDP, CLS_UDP, 2'd0, 16'd60}},
			'{'{32'h0B00_0001, PROTO_TCP, 16'd443, 16'd60, 1'b0, 64'd1200, 1'b0, 1'b1}, 1'b0,
				none},
			'{'{32'h0B00_0001, PROTO_ICMP, 16'd80, 16'd60, 1'b0, 64'd1300, 1'b0, 1'b0}, 1'b0,
				none},
			'{'{32'h0B00_0001, PROTO_ICMP, 16'd443, 16'd64, 1'b0, 64'd1400, 1'b0, 1'b0}, 1'b0,
				none},
			'{'{32'h0B00_0001, PROTO_ICMP, 16'd443, 16'd64, 1'b0, 64'd1500, 1'b0, 1'b0}, 1'b0,
				none},
			'{'{32'h0B00_0001, 8'd47, 16'd443, 16'd64, 1'b0, 64'd1600, 1'b0, 1'b0}, 1'b0,
				none},
			'{'{32'h0B00_0001, PROTO_ICMP, 16'd443, 16'd64, 1'b0, 64'd1700, 1'b0, 1'b0}, 1'b0,
				none},
			'{'{32'h0B00_0001, PROTO_ICMP, 16'd443, 16'd64, 1'b0, 64'd1800, 1'b0, 1'b0}, 1'b0,
				none},
			'{'{32'h0B00_0001, PROTO_ICMP, 16'd443, 16'd64, 1'b0, 64'd1900, 1'b0, 1'b0}, 1'b0,
				none},
			'{'{32'h0B00_0001, PROTO_ICMP, 16'd443, 16'd64, 1'b0, 64'd500, 1'b0, 1'b0}, 1'b0,
				none}
		};
		foreach (rows[i]) send_word(rows[i].p, rows[i].typed, rows[i].v);
		drain();

		// Random phases, extremes of the limits among them.
		phases[0] = '{3'd1, 16'd0, 32'd5, 32'd0, 32'd2, 32'd3, 32'd2, 48'd0};
		phases[1] = '{3'd1, 16'd80, 32'd0, 32'd8, 32'd0, 32'd0, 32'd0, 48'd3000};
		phases[2] = '{3'd7, 16'd0, MAX32, MAX32, MAX32, MAX32, MAX32, MAX48};
		phases[3] = '{3'd3, 16'd0, 32'd1, 32'd0, 32'd1, 32'd1, 32'd1, 48'd0};
		phases[4] = '{3'd5, 16'($urandom), 32'($urandom_range(1, 12)),
			32'($urandom_range(0, 12)), 32'($urandom_range(1, 12)), 32'($urandom_range(1, 12)),
			32'($urandom_range(1, 12)), 48'($urandom_range(1000, 60000))};
		for (k = 0; k < 5; k++) begin
			load_regs(phases[k]);
			for (i = 0; i < 30; i++) begin
				// Hold both sides busy for a long stretch in the middle of the run.
				quiet = words_sent >= 50 && words_sent < 130;
				send_word(random_packet(), 1'b0, none);
			end
			quiet = 1'b0;
			drain();
		end

		// Fill the table, then show that further new sources pass untracked.
		load_regs('{3'd1, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 48'd0});
		for (i = 0; i < TABLE_ENTRIES + 4; i++) begin
			clock_ns += 1000;
			send_word('{32'hC000_0000 + i, PROTO_ICMP, 16'd0, 16'd64, 1'b0, clock_ns,
				1'b0, 1'b0}, 1'b0, none);
		end
		for (i = 0; i < 12; i++) send_word(random_packet(), 1'b0, none);
		drain();
		repeat (20) @(posedge clk);

		if (fails == 0) begin
			$display("per_source_flood_limiter: match");
		end else begin
			$display("per_source_flood_limiter: mismatch");
		end
		$finish;
	end
endmodule
